/* rtl/core/desp_pkg.sv */
// shared types and constants for the der signature parser
// no dependencies; imported by desp_step and der_ecdsa_signature_parser
`default_nettype none

package desp_pkg;

    localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
    localparam logic [7:0] TAG_INTEGER   = 8'h02;
    localparam logic [7:0] LONG_FORM_BIT = 8'h80;
    localparam logic [7:0] SEEN_MAX      = 8'hff;

    typedef enum logic [2:0] {
        PH_SEQ_TAG = 3'd0,
        PH_SEQ_LEN = 3'd1,
        PH_R_TAG   = 3'd2,
        PH_R_LEN   = 3'd3,
        PH_R_DATA  = 3'd4,
        PH_S_TAG   = 3'd5,
        PH_S_LEN   = 3'd6,
        PH_S_DATA  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_LONGFORM  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ROLE_STRUCT  = 2'd0,
        ROLE_R       = 2'd1,
        ROLE_S       = 2'd2,
        ROLE_IGNORED = 2'd3
    } role_t;

    typedef struct packed {
        phase_t      phase;
        logic [6:0]  seq_len;
        logic [6:0]  remaining;
        logic [7:0]  seen;
        status_t     hdr_err;
        status_t     late_err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_SEQ_TAG,
        seq_len:   7'd0,
        remaining: 7'd0,
        seen:      8'd0,
        hdr_err:   ST_OK,
        late_err:  ST_OK
    };

endpackage

`default_nettype wire

/* rtl/core/der_ecdsa_signature_parser.sv */
// top level of the der signature parser: input register, parse step, result register
// depends on desp_pkg and desp_step
`default_nettype none

// Parses a DER encoded signature, SEQUENCE { INTEGER r, INTEGER s }, one byte
// per beat, with last_byte marking the final byte of a signature. Every byte
// comes back as one result beat carrying the byte itself and its role:
// structure (tags and lengths), r content, s content, or ignored (after an
// error or after s is complete). Only short-form lengths are supported. The
// result beat for the last byte has done_res set and carries the status: ok,
// malformed, or long-form length unsupported; status reads zero otherwise.
// After the last byte the parser is back in its reset state, ready for the
// next signature. The block takes one byte per cycle while out_stall is low:
// a byte is held in the input register, goes through the combinational phase
// update and lands in the result register, which holds it while out_stall
// is high and then also stalls the input. The phase, lengths and byte count
// are updated in that one step, which is what bounds the rate at one beat
// per cycle.
module der_ecdsa_signature_parser
    import desp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      value_byte,
    output logic [1:0]      byte_role,
    output logic            done_res,
    output logic [1:0]      status
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parse state
    parse_state_t state_reg;
    parse_state_t state_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    role_t      out_role_reg;
    logic       out_done_reg;
    status_t    out_status_reg;

    role_t   step_role;
    status_t step_status;
    logic    advance;
    logic    in_take;

    // a byte moves on when the result register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    desp_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .byte_role (step_role),
        .status    (step_status)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // parse state advances once per byte handed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= in_byte_reg;
            out_role_reg   <= step_role;
            out_done_reg   <= in_last_reg;
            out_status_reg <= step_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_byte = out_byte_reg;
    assign byte_role  = out_role_reg;
    assign done_res   = out_done_reg;
    assign status     = out_status_reg;

    // status only shows on the final beat of a signature
    a_status_only_on_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |-> (out_status_reg == ST_OK))
        else $error("nonzero status on a beat that is not the last");

    // a final byte returns the parser to its reset state
    a_reset_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (state_reg == STATE_RESET))
        else $error("parse state not cleared after the last byte");

    // state only changes when a byte goes through
    a_state_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parse state changed without a byte");

    // a byte waiting in the input register is never overwritten
    a_no_overrun: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> in_stall)
        else $error("input register not protected while blocked");

endmodule

`default_nettype wire

/* rtl/core/desp_step.sv */
// one-byte step of the der parse: next state, byte role and final status
// depends on desp_pkg
`default_nettype none

module desp_step
    import desp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output parse_state_t nxt,
    output role_t        byte_role,
    output status_t      status
);

    parse_state_t upd;
    logic [7:0]   len_plus_two;

    always_comb
    begin
        upd       = cur;
        byte_role = ROLE_STRUCT;
        if (cur.seen != SEEN_MAX)
        begin
            upd.seen = cur.seen + 8'd1;
        end

        if (cur.hdr_err != ST_OK || cur.late_err != ST_OK)
        begin
            byte_role = ROLE_IGNORED;
        end
        else
        begin
            unique case (cur.phase)
                PH_SEQ_TAG:
                begin
                    if (data_byte != TAG_SEQUENCE) upd.hdr_err = ST_MALFORMED;
                    else upd.phase = PH_SEQ_LEN;
                end
                PH_SEQ_LEN:
                begin
                    if ((data_byte & LONG_FORM_BIT) != 8'd0)
                    begin
                        upd.hdr_err = ST_LONGFORM;
                    end
                    else
                    begin
                        upd.seq_len = data_byte[6:0];
                        upd.phase   = PH_R_TAG;
                    end
                end
                PH_R_TAG, PH_S_TAG:
                begin
                    if (data_byte != TAG_INTEGER) upd.late_err = ST_MALFORMED;
                    else if (cur.phase == PH_R_TAG) upd.phase = PH_R_LEN;
                    else upd.phase = PH_S_LEN;
                end
                PH_R_LEN, PH_S_LEN:
                begin
                    if ((data_byte & LONG_FORM_BIT) != 8'd0)
                    begin
                        upd.late_err = ST_LONGFORM;
                    end
                    else
                    begin
                        upd.remaining = data_byte[6:0];
                        if (cur.phase == PH_S_LEN) upd.phase = PH_S_DATA;
                        else if (data_byte == 8'd0) upd.phase = PH_S_TAG;
                        else upd.phase = PH_R_DATA;
                    end
                end
                PH_R_DATA:
                begin
                    byte_role     = ROLE_R;
                    upd.remaining = cur.remaining - 7'd1;
                    if (cur.remaining == 7'd1) upd.phase = PH_S_TAG;
                end
                PH_S_DATA:
                begin
                    if (cur.remaining == 7'd0)
                    begin
                        upd.late_err = ST_MALFORMED;
                        byte_role    = ROLE_IGNORED;
                    end
                    else
                    begin
                        upd.remaining = cur.remaining - 7'd1;
                        byte_role     = ROLE_S;
                    end
                end
            endcase
        end
    end

    assign len_plus_two = {1'b0, upd.seq_len} + 8'd2;

    // status order: header, still in header, length mismatch, later, incomplete
    always_comb
    begin
        status = ST_OK;
        if (last_byte)
        begin
            if (upd.hdr_err != ST_OK) status = upd.hdr_err;
            else if (upd.phase == PH_SEQ_TAG || upd.phase == PH_SEQ_LEN)
                status = ST_MALFORMED;
            else if (len_plus_two != upd.seen) status = ST_MALFORMED;
            else if (upd.late_err != ST_OK) status = upd.late_err;
            else if (upd.phase != PH_S_DATA || upd.remaining != 7'd0)
                status = ST_MALFORMED;
            else status = ST_OK;
        end
    end

    assign nxt = last_byte ? STATE_RESET : upd;

endmodule

`default_nettype wire
